// ===== hdl/ptc_pkg.sv =====
// package for the pressure/temperature compensation block
// holds shared constants and the unit operation codes; no dependencies
package ptc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned NumCfg = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DataW-1:0] CalAc1Ac2Rst = 32'd26804152;
  localparam logic [DataW-1:0] CalAc3Ac4Rst = 32'd3352395749;
  localparam logic [DataW-1:0] CalAc5Ac6Rst = 32'd2146785905;
  localparam logic [DataW-1:0] CalB1B2Rst   = 32'd405667844;
  localparam logic [DataW-1:0] CalMcMdRst   = 32'd3724086068;

  localparam logic [CfgIdxW-1:0] RegAc1Ac2 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAc3Ac4 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAc5Ac6 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegB1B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMcMd   = 3'd4;

  // shared unit operation codes
  localparam logic [1:0] OpMul = 2'd0;
  localparam logic [1:0] OpAdd = 2'd1;
  localparam logic [1:0] OpAsr = 2'd2;
  localparam logic [1:0] OpLsr = 2'd3;

  localparam logic [DataW-1:0] KB6Off  = 32'd4000;
  localparam logic [DataW-1:0] KP1     = 32'd3038;
  localparam logic [DataW-1:0] KP2     = 32'hFFFF_E343; // -7357
  localparam logic [DataW-1:0] KP3     = 32'd3791;
  localparam logic [DataW-1:0] KScale  = 32'd50000;
  localparam logic [DataW-1:0] KSign   = 32'h8000_0000;
  localparam logic [DataW-1:0] KHalf   = 32'd32768;

  // divider request / response bundle
  typedef struct packed {
    logic             start;
    logic             signed_op;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/pressure_temperature_compensation_unit.sv =====
// Compensation block: one shared multiply/add/shift unit runs a small
// microprogram, each operation issued and then written back, with a serial
// divider for the single division. A zero divisor ends the run early, before
// the division, with divide_error_o set and a zero result word.
// in_ready_o is low from acceptance until the result word is taken.
// depends on ptc_pkg, ptc_alu, ptc_div
module pressure_temperature_compensation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [15:0] raw_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] compensated_o,
  output logic        divide_error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import ptc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [DataW-1:0] c0_q, c1_q, c2_q, c3_q, c4_q, b5_q, b5_d;
  logic [1:0]  st_q, st_d;
  logic [5:0]  pc_q, pc_d;
  logic        kind_q, err_q, err_d;
  logic [15:0] raw_q;
  logic [DataW-1:0] r_q [8];
  logic [DataW-1:0] r_d [8];
  logic [DataW-1:0] res_q, res_d;

  logic [1:0]       op;
  logic [DataW-1:0] opa, opb, alu_y;
  logic [4:0]       sh;
  logic [2:0]       dst;
  logic             wr;
  div_req_t         dreq;
  div_rsp_t         drsp;

  function automatic logic [DataW-1:0] sx(input logic [15:0] v);
    sx = {{16{v[15]}}, v};
  endfunction

  // coefficient views
  logic [DataW-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
  assign ac1 = sx(c0_q[31:16]); assign ac2 = sx(c0_q[15:0]);
  assign ac3 = sx(c1_q[31:16]); assign ac4 = {16'd0, c1_q[15:0]};
  assign ac5 = {16'd0, c2_q[31:16]}; assign ac6 = {16'd0, c2_q[15:0]};
  assign b1 = sx(c3_q[31:16]); assign b2 = sx(c3_q[15:0]);
  assign mc = sx(c4_q[31:16]); assign md = sx(c4_q[15:0]);
  assign ut = {16'd0, raw_q};

  ptc_alu u_alu (.clk_i, .op_i(op), .a_i(opa), .b_i(opb), .sh_i(sh), .y_o(alu_y));
  ptc_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // microprogram: each step issues one op; the ALU registers the result, which is then written into r[dst]
  always_comb begin
    op = OpAdd; opa = '0; opb = '0; sh = '0; dst = 3'd0; wr = 1'b0;
    if (!kind_q) begin
      unique case (pc_q)
        6'd0: begin op = OpAdd; opa = ut; opb = ~ac6 + 1'b1; dst = 3'd0; wr = 1'b1; end
        6'd1: begin op = OpMul; opa = r_q[0]; opb = ac5; dst = 3'd0; wr = 1'b1; end
        6'd2: begin op = OpAsr; opa = r_q[0]; sh = 5'd15; dst = 3'd0; wr = 1'b1; end // x1
        6'd3: begin op = OpAdd; opa = r_q[0]; opb = md; dst = 3'd1; wr = 1'b1; end  // den
        6'd5: begin op = OpAdd; opa = r_q[0]; opb = r_q[2]; dst = 3'd3; wr = 1'b1; end // b5
        6'd6: begin op = OpAdd; opa = r_q[3]; opb = 32'd8; dst = 3'd4; wr = 1'b1; end
        6'd7: begin op = OpAsr; opa = r_q[4]; sh = 5'd4; dst = 3'd4; wr = 1'b1; end
        default: ;
      endcase
    end else begin
      unique case (pc_q)
        6'd0:  begin op = OpAdd; opa = b5_q; opb = ~KB6Off + 1'b1; dst = 3'd0; wr = 1'b1; end
        6'd1:  begin op = OpMul; opa = r_q[0]; opb = r_q[0]; dst = 3'd1; wr = 1'b1; end
        6'd2:  begin op = OpAsr; opa = r_q[1]; sh = 5'd12; dst = 3'd1; wr = 1'b1; end // sq
        6'd3:  begin op = OpMul; opa = b2; opb = r_q[1]; dst = 3'd2; wr = 1'b1; end
        6'd4:  begin op = OpAsr; opa = r_q[2]; sh = 5'd11; dst = 3'd2; wr = 1'b1; end
        6'd5:  begin op = OpMul; opa = ac2; opb = r_q[0]; dst = 3'd3; wr = 1'b1; end
        6'd6:  begin op = OpAsr; opa = r_q[3]; sh = 5'd11; dst = 3'd3; wr = 1'b1; end
        6'd7:  begin op = OpAdd; opa = r_q[2]; opb = r_q[3]; dst = 3'd2; wr = 1'b1; end
        6'd8:  begin op = OpAdd; opa = ac1 << 2; opb = r_q[2]; dst = 3'd2; wr = 1'b1; end
        6'd9:  begin op = OpAdd; opa = r_q[2]; opb = 32'd2; dst = 3'd2; wr = 1'b1; end
        6'd10: begin op = OpAsr; opa = r_q[2]; sh = 5'd2; dst = 3'd2; wr = 1'b1; end // b3
        6'd11: begin op = OpMul; opa = ac3; opb = r_q[0]; dst = 3'd3; wr = 1'b1; end
        6'd12: begin op = OpAsr; opa = r_q[3]; sh = 5'd13; dst = 3'd3; wr = 1'b1; end
        6'd13: begin op = OpMul; opa = b1; opb = r_q[1]; dst = 3'd4; wr = 1'b1; end
        6'd14: begin op = OpAsr; opa = r_q[4]; sh = 5'd16; dst = 3'd4; wr = 1'b1; end
        6'd15: begin op = OpAdd; opa = r_q[3]; opb = r_q[4]; dst = 3'd3; wr = 1'b1; end
        6'd16: begin op = OpAdd; opa = r_q[3]; opb = 32'd2; dst = 3'd3; wr = 1'b1; end
        6'd17: begin op = OpAsr; opa = r_q[3]; sh = 5'd2; dst = 3'd3; wr = 1'b1; end
        6'd18: begin op = OpAdd; opa = r_q[3]; opb = KHalf; dst = 3'd3; wr = 1'b1; end
        6'd19: begin op = OpMul; opa = ac4; opb = r_q[3]; dst = 3'd3; wr = 1'b1; end
        6'd20: begin op = OpLsr; opa = r_q[3]; sh = 5'd15; dst = 3'd3; wr = 1'b1; end // b4
        6'd21: begin op = OpAdd; opa = ut; opb = ~r_q[2] + 1'b1; dst = 3'd4; wr = 1'b1; end
        6'd22: begin op = OpMul; opa = r_q[4]; opb = KScale; dst = 3'd4; wr = 1'b1; end // b7
        6'd23: begin op = OpAdd; opa = r_q[4]; opb = r_q[4]; dst = 3'd5; wr = 1'b1; end
        // step 24 starts the divider, step 25 doubles the quotient if needed
        6'd25: begin op = OpAdd; opa = r_q[6]; opb = r_q[4] < KSign ? '0 : r_q[6];
                 dst = 3'd6; wr = 1'b1; end // p
        6'd26: begin op = OpAsr; opa = r_q[6]; sh = 5'd8; dst = 3'd0; wr = 1'b1; end
        6'd27: begin op = OpMul; opa = r_q[0]; opb = r_q[0]; dst = 3'd0; wr = 1'b1; end
        6'd28: begin op = OpMul; opa = r_q[0]; opb = KP1; dst = 3'd0; wr = 1'b1; end
        6'd29: begin op = OpAsr; opa = r_q[0]; sh = 5'd16; dst = 3'd0; wr = 1'b1; end
        6'd30: begin op = OpMul; opa = KP2; opb = r_q[6]; dst = 3'd1; wr = 1'b1; end
        6'd31: begin op = OpAsr; opa = r_q[1]; sh = 5'd16; dst = 3'd1; wr = 1'b1; end
        6'd32: begin op = OpAdd; opa = r_q[0]; opb = r_q[1]; dst = 3'd0; wr = 1'b1; end
        6'd33: begin op = OpAdd; opa = r_q[0]; opb = KP3; dst = 3'd0; wr = 1'b1; end
        6'd34: begin op = OpAsr; opa = r_q[0]; sh = 5'd4; dst = 3'd0; wr = 1'b1; end
        6'd35: begin op = OpAdd; opa = r_q[6]; opb = r_q[0]; dst = 3'd4; wr = 1'b1; end
        default: ;
      endcase
    end
  end

  // sequencing: every step runs as an issue phase and then a write-back phase
  logic phase_q;
  logic [5:0] last_pc;
  assign last_pc = kind_q ? 6'd36 : 6'd8;

  always_comb begin
    st_d = st_q; pc_d = pc_q; err_d = err_q; b5_d = b5_q; res_d = res_q;
    dreq = '0;
    r_d = r_q;
    if (phase_q && wr && (st_q == StRun)) r_d[dst] = alu_y;
    if (drsp.done) r_d[6] = drsp.quo;
    unique case (st_q)
      StIdle: if (in_valid_i) begin
        st_d = StRun; pc_d = '0; err_d = 1'b0;
      end
      StRun: if (phase_q) begin
        pc_d = pc_q + 6'd1;
        if (!kind_q && pc_q == 6'd4) begin
          if (r_q[1] == '0) begin
            err_d = 1'b1; st_d = StOut; res_d = '0;
          end else begin
            dreq.start = 1'b1; dreq.signed_op = 1'b1; dreq.num = mc << 11;
            dreq.den = r_q[1]; st_d = StDiv;
          end
        end else if (kind_q && pc_q == 6'd24) begin
          if (r_q[3] == '0) begin
            err_d = 1'b1; st_d = StOut; res_d = '0;
          end else begin
            dreq.start = 1'b1; dreq.signed_op = 1'b0;
            dreq.num = (r_q[4] < KSign) ? r_q[5] : r_q[4];
            dreq.den = r_q[3]; st_d = StDiv;
          end
        end else if (pc_q == last_pc) begin
          st_d = StOut; res_d = r_q[4];
          if (!kind_q) b5_d = r_q[3];
        end
      end
      StDiv: if (drsp.done) begin
        st_d = StRun; r_d[2] = drsp.quo;
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; pc_q <= '0; phase_q <= 1'b0; b5_q <= '0; err_q <= 1'b0;
      c0_q <= CalAc1Ac2Rst; c1_q <= CalAc3Ac4Rst; c2_q <= CalAc5Ac6Rst;
      c3_q <= CalB1B2Rst; c4_q <= CalMcMdRst;
    end else begin
      st_q <= st_d; pc_q <= pc_d; b5_q <= b5_d; err_q <= err_d;
      phase_q <= (st_q == StRun) ? ~phase_q : 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegAc1Ac2: c0_q <= cfg_data_i;
          RegAc3Ac4: c1_q <= cfg_data_i;
          RegAc5Ac6: c2_q <= cfg_data_i;
          RegB1B2:   c3_q <= cfg_data_i;
          RegMcMd:   c4_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; res_q <= res_d;
    if (st_q == StIdle && in_valid_i) begin
      kind_q <= req_type_i; raw_q <= raw_sample_i;
    end
  end

  assign in_ready_o     = (st_q == StIdle);
  assign out_valid_o    = (st_q == StOut);
  assign result_kind_o  = kind_q;
  assign compensated_o  = res_q;
  assign divide_error_o = err_q;
  assign cfg_ready_o    = 1'b1;
endmodule

// ===== hdl/ptc_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on ptc_pkg
module ptc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::div_req_t req_i,
  output ptc_pkg::div_rsp_t rsp_o
);
  import ptc_pkg::*;

  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [DataW:0]   trial;
  logic [DataW-1:0] mn, md;

  always_comb begin
    mn = (req_i.signed_op && req_i.num[DataW-1]) ? (~req_i.num + 1'b1) : req_i.num;
    md = (req_i.signed_op && req_i.den[DataW-1]) ? (~req_i.den + 1'b1) : req_i.den;
    trial = {rem_q, quo_q[DataW-1]} - {1'b0, den_q};
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0; quo_d = mn; den_d = md; cnt_d = 6'(DataW); busy_d = 1'b1;
      neg_d = req_i.signed_op && (req_i.num[DataW-1] ^ req_i.den[DataW-1]);
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

// ===== hdl/ptc_alu.sv =====
// shared arithmetic unit: registered 32x32 wrap multiply, add, arithmetic and logical shift
// depends on ptc_pkg
module ptc_alu (
  input  logic                    clk_i,
  input  logic [1:0]              op_i,
  input  logic [ptc_pkg::DataW-1:0] a_i,
  input  logic [ptc_pkg::DataW-1:0] b_i,
  input  logic [4:0]              sh_i,
  output logic [ptc_pkg::DataW-1:0] y_o
);
  import ptc_pkg::*;

  logic [DataW-1:0] y_d;

  always_comb begin
    unique case (op_i)
      OpMul:   y_d = a_i * b_i;
      OpAdd:   y_d = a_i + b_i;
      OpAsr:   y_d = DataW'($signed(a_i) >>> sh_i);
      OpLsr:   y_d = a_i >> sh_i;
      default: y_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) y_o <= y_d;
endmodule
